// ----- hw/rtl/plm_pkg.sv -----
// Shared types and constants of the positional list engine.
package plm_pkg;

   // List storage geometry.
   localparam int CAPACITY   = 64;
   localparam int WORD_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // Fixed field widths of the transfer structs.
   localparam int POS_W  = 7;
   localparam int DATA_W = 32;
   localparam int LEN_W  = 7;

   // Width used to compare a position against the entry count.
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Operation codes.
   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_READ   = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_OOB  = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef logic [WORD_WIDTH-1:0] word_type;

   // Request and response transfers.
   typedef struct packed {
      kind_type           kind;
      logic [POS_W-1:0]   position;
      logic [DATA_W-1:0]  value_in;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [DATA_W-1:0]  value_out;
      logic [LEN_W-1:0]   length_now;
   } rsp_type;

   // Per-cell update controls.
   typedef struct packed {
      logic load;
      logic take_left;
      logic take_right;
   } cell_ctrl_type;

endpackage

// ----- hw/rtl/positional_list_engine_top.sv -----
// Positional list engine: a row of CAPACITY cells; the cells that move all shift in the same cycle.
// A response appears in the cycle after its request transfer.
// Throughput: one operation per cycle; busy is never raised.
// Every insert, remove, read or clear completes in the cycle of its transfer.
// Reset clears the entry count and the response strobe; the list reads as empty.
// The receiver cannot stall: each response is held for exactly one cycle.
module positional_list_engine_top
   import plm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             strobe_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic             accept;
   logic             op_ins;
   logic             op_rem;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   word_type         new_word;
   word_type         rd_word;

   word_type         cell_word [CAPACITY];
   cell_ctrl_type    cell_ctrl [CAPACITY];

   assign busy     = 1'b0;
   assign accept   = start & ~busy;
   assign pos_ext  = CMP_W'(req_item.position);
   assign cnt_ext  = CMP_W'(count_ff);
   assign new_word = WORD_WIDTH'(req_item.value_in);
   assign rd_word  = cell_word[req_item.position[IDX_W-1:0]];

   // Decode the operation, check bounds and build the response.
   always_comb begin
      count_in          = count_ff;
      op_ins            = 1'b0;
      op_rem            = 1'b0;
      rsp_in.status     = STATUS_OK;
      rsp_in.value_out  = '0;
      unique case (req_item.kind)
         KIND_INSERT: begin
            if (pos_ext > cnt_ext) begin
               rsp_in.status = STATUS_OOB;
            end else if (count_ff == CNT_W'(CAPACITY)) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               op_ins   = accept;
               count_in = count_ff + CNT_W'(1);
            end
         end
         KIND_REMOVE: begin
            if (pos_ext >= cnt_ext) begin
               rsp_in.status = STATUS_OOB;
            end else begin
               op_rem   = accept;
               count_in = count_ff - CNT_W'(1);
            end
         end
         KIND_READ: begin
            if (pos_ext >= cnt_ext) begin
               rsp_in.status = STATUS_OOB;
            end else begin
               rsp_in.value_out = DATA_W'(rd_word);
            end
         end
         KIND_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      rsp_in.length_now = LEN_W'(count_in);
   end

   // Row of cells: each takes its own shift control and neighbor words.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      word_type left_word;
      word_type right_word;

      always_comb begin
         cell_ctrl[i].load       = op_ins & (pos_ext == CMP_W'(i));
         cell_ctrl[i].take_left  = op_ins & (pos_ext < CMP_W'(i));
         cell_ctrl[i].take_right = op_rem & (pos_ext <= CMP_W'(i));
      end

      if (i == 0) begin : g_first
         assign left_word = new_word;
      end else begin : g_inner_left
         assign left_word = cell_word[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_inner_right
         assign right_word = cell_word[i+1];
      end

      plm_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .new_word   (new_word),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (cell_word[i])
      );
   end

   // Count and response strobe carry reset; the response payload does not.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ----- hw/rtl/plm_cell.sv -----
// One storage cell of the list: holds a word and trades it with its neighbors.
module plm_cell
   import plm_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  word_type      new_word,
   input  word_type      left_word,
   input  word_type      right_word,
   output word_type      word
);

   word_type word_ff;
   word_type word_in;

   // Select the next content: new word, the lower neighbor, the upper neighbor or hold.
   always_comb begin
      word_in = word_ff;
      if (ctrl.load) begin
         word_in = new_word;
      end else if (ctrl.take_left) begin
         word_in = left_word;
      end else if (ctrl.take_right) begin
         word_in = right_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// ----- tb/list_engine_checker.sv -----
// Response checker for the positional list engine: tracks the list and compares every response.
module list_engine_checker
   import plm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_strobe,
   input  rsp_type rsp_item,
   output int      fail_count,
   output int      outstanding,
   output int      checked_count,
   output int      full_hits,
   output int      oob_hits
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the list contents and its length.
   word_type list_words [CAPACITY];
   int       list_len = 0;

   // Responses still owed by the engine, oldest first.
   rsp_type  awaited_rsp [$];

   int errors  = 0;
   int checked = 0;
   int fulls   = 0;
   int oobs    = 0;

   // Apply one list operation to the shadow list and build the response it must give.
   task automatic apply_list_op(input req_type op, output rsp_type result);
      int       pos;
      int       i;
      word_type word;
      pos = int'(op.position);
      word = op.value_in[WORD_WIDTH-1:0];
      result = '0;
      result.status = STATUS_OK;
      case (op.kind)
         KIND_INSERT: begin
            // The bounds check comes before the full check.
            if (pos > list_len) begin
               result.status = STATUS_OOB;
            end else if (list_len >= CAPACITY) begin
               result.status = STATUS_FULL;
            end else begin
               for (i = list_len; i > pos; i--) begin
                  list_words[i] = list_words[i-1];
               end
               list_words[pos] = word;
               list_len++;
            end
         end
         KIND_REMOVE: begin
            if (pos >= list_len) begin
               result.status = STATUS_OOB;
            end else begin
               for (i = pos; i + 1 < list_len; i++) begin
                  list_words[i] = list_words[i+1];
               end
               list_len--;
            end
         end
         KIND_READ: begin
            if (pos >= list_len) begin
               result.status = STATUS_OOB;
            end else begin
               result.value_out = DATA_W'(list_words[pos]);
            end
         end
         KIND_CLEAR: begin
            list_len = 0;
         end
         default: begin
         end
      endcase
      result.length_now = LEN_W'(list_len);
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         list_len = 0;
         awaited_rsp.delete();
      end else begin
         // A response transfer is matched against the oldest expectation.
         if (rsp_strobe) begin
            got = rsp_item;
            if (awaited_rsp.size() == 0) begin
               errors++;
               $display("%0t ns: response with nothing expected: status %0d value %h length %0d",
                        $time, got.status, got.value_out, got.length_now);
            end else begin
               want = awaited_rsp.pop_front();
               checked++;
               if (want.status == STATUS_FULL) fulls++;
               if (want.status == STATUS_OOB) oobs++;
               if (got.status !== want.status) begin
                  errors++;
                  $display("%0t ns: status mismatch: expected %0d, actual %0d",
                           $time, want.status, got.status);
               end
               if (got.value_out !== want.value_out) begin
                  errors++;
                  $display("%0t ns: value_out mismatch: expected %h, actual %h",
                           $time, want.value_out, got.value_out);
               end
               if (got.length_now !== want.length_now) begin
                  errors++;
                  $display("%0t ns: length_now mismatch: expected %0d, actual %0d",
                           $time, want.length_now, got.length_now);
               end
            end
         end
         // A request transfer adds one expected response.
         if (start && !busy) begin
            apply_list_op(req_item, want);
            awaited_rsp.push_back(want);
         end
      end
      fail_count    <= errors;
      outstanding   <= awaited_rsp.size();
      checked_count <= checked;
      full_hits     <= fulls;
      oob_hits      <= oobs;
   end

endmodule

// ----- tb/positional_list_engine_top_test.sv -----
// Stimulus and verdict for the positional list engine, with the response checker beside it.
module positional_list_engine_top_test;
   import plm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   int fail_count;
   int outstanding;
   int checked_count;
   int full_hits;
   int oob_hits;

   // Length last reported by the engine, used to aim positions near the live range.
   int len_hint = 0;
   int sent = 0;
   bit idle_on = 1'b1;

   always #10 clock = ~clock;

   positional_list_engine_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   list_engine_checker list_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .checked_count (checked_count),
      .full_hits     (full_hits),
      .oob_hits      (oob_hits)
   );

   // Advance one clock and pick up the latest reported length.
   task automatic tick();
      @(posedge clock);
      if (rsp_strobe) len_hint = int'(rsp_item.length_now);
   endtask

   // Present one operation and hold it until the transfer happens.
   task automatic send_op(input kind_type kind, input int pos, input logic [DATA_W-1:0] val);
      req_type item;
      item.kind = kind;
      item.position = POS_W'(pos);
      item.value_in = val;
      if (idle_on) begin
         while ($urandom_range(0, 99) < 30) begin
            start <= 1'b0;
            tick();
         end
      end
      start <= 1'b1;
      req_item <= item;
      do tick(); while (busy);
      sent++;
   endtask

   // One random operation, drawn with the given weights per kind.
   task automatic random_op(input int ins_w, input int rem_w, input int rd_w, input int clr_w);
      int               pick;
      int               pos;
      int               top_pos;
      kind_type         kind;
      logic [DATA_W-1:0] val;
      pick = $urandom_range(0, ins_w + rem_w + rd_w + clr_w - 1);
      if (pick < ins_w) kind = KIND_INSERT;
      else if (pick < ins_w + rem_w) kind = KIND_REMOVE;
      else if (pick < ins_w + rem_w + rd_w) kind = KIND_READ;
      else kind = KIND_CLEAR;
      // Mostly positions up to the boundary of the list, sometimes anywhere in the field.
      top_pos = (kind == KIND_INSERT) ? len_hint + 1 : len_hint;
      if ($urandom_range(0, 9) < 8) pos = $urandom_range(0, top_pos);
      else pos = $urandom_range(0, 127);
      case ($urandom_range(0, 9))
         0: val = '0;
         1: val = '1;
         default: val = $urandom;
      endcase
      send_op(kind, pos, val);
   endtask

   // Stop sending until every expected response has come back.
   task automatic wait_drained();
      start <= 1'b0;
      tick();
      while (outstanding != 0) tick();
   endtask

   initial begin
      repeat (3) tick();
      reset <= 1'b0;

      // Directed: empty list, bounds on insert, remove and read, front, middle and end positions.
      send_op(KIND_CLEAR,  127, 32'h0000_0000);
      send_op(KIND_READ,   0,   32'hFFFF_FFFF);
      send_op(KIND_REMOVE, 0,   32'h0000_0000);
      send_op(KIND_INSERT, 1,   32'h1234_5678);
      send_op(KIND_INSERT, 127, 32'hFFFF_FFFF);
      send_op(KIND_INSERT, 0,   32'hFFFF_FFFF);
      send_op(KIND_INSERT, 1,   32'h0000_0000);
      send_op(KIND_INSERT, 0,   32'hA5A5_A5A5);
      send_op(KIND_INSERT, 1,   32'h5A5A_5A5A);
      send_op(KIND_READ,   0,   32'h0000_0000);
      send_op(KIND_READ,   3,   32'h0000_0000);
      send_op(KIND_READ,   4,   32'h0000_0000);
      send_op(KIND_READ,   127, 32'h0000_0000);
      send_op(KIND_REMOVE, 1,   32'h0000_0000);
      send_op(KIND_REMOVE, 2,   32'h0000_0000);
      send_op(KIND_REMOVE, 2,   32'h0000_0000);
      send_op(KIND_REMOVE, 0,   32'h0000_0000);
      send_op(KIND_INSERT, 1,   32'h7FFF_FFFF);
      send_op(KIND_CLEAR,  64,  32'hFFFF_FFFF);
      send_op(KIND_READ,   0,   32'h0000_0000);
      send_op(KIND_INSERT, 0,   32'h8000_0000);
      send_op(KIND_REMOVE, 0,   32'h0000_0000);

      // Fill the list to capacity and keep pushing on it, back to back.
      idle_on = 1'b0;
      repeat (130) random_op(80, 8, 12, 0);
      idle_on = 1'b1;
      wait_drained();

      // Reads and inserts while the list sits at or near full.
      repeat (60) random_op(40, 10, 50, 0);

      // Drain the list down to empty and past it.
      repeat (120) random_op(10, 70, 20, 0);

      // Mixed traffic with an occasional clear.
      repeat (240) random_op(45, 35, 17, 3);

      wait_drained();
      repeat (4) tick();

      $display("Summary: %0d operations sent, %0d responses checked.", sent, checked_count);
      $display("Summary: %0d list-full and %0d out-of-range responses seen.",
               full_hits, oob_hits);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog in case the engine stops responding.
   initial begin
      #400us;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
